### design/bitmap_first_fit_run_allocator_unit_defines.svh
// Assertion macros for the bitmap first-fit run allocator
`ifndef BITMAP_FIRST_FIT_RUN_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FIT_RUN_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFFRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BFFRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bffra_pkg.sv
// Shared types, codes and helper functions of the bitmap first-fit run allocator
`timescale 1ns / 1ps
`default_nettype none

package bffra_pkg;

    localparam int MAP_BYTES  = 128;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAP_BYTES + 3) / 4;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_COUNT = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH   = 2'd1;
    localparam logic [1:0] ST_NO_SPACE     = 2'd2;
    localparam logic [1:0] ST_INCONSISTENT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RUN_CNT,
        S_RUN_CLR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       cfg_write;
        logic       load_word;
        logic       load_count;
        logic       set_code;
        logic [1:0] code;
        logic       scan_next;
        logic       scan_hit;
        logic       run_count;
        logic       run_clear;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       req_zero;
        logic       free_zero;
        logic       scan_end;
        logic       scan_found;
        logic       run_done;
        logic       out_busy;
    } stat_t;

    // bits below k set, k in 0..32
    function automatic logic [31:0] low_mask(input logic [5:0] k);
        logic [31:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (6'(i) < k);
        end
        return m;
    endfunction

    // index of lowest set bit, 32 when none
    function automatic logic [5:0] lsb_index(input logic [31:0] v);
        logic [31:0] oh;
        logic [5:0]  idx;
        oh  = v & (~v + 32'd1);
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                idx[4:0] = idx[4:0] | 5'(i);
            end
        end
        if (v == '0) begin
            idx = 6'(WORD_BITS);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### design/bitmap_first_fit_run_allocator_unit.sv
// Top level of the bitmap first-fit run allocator
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_first_fit_run_allocator_unit_defines.svh"

// Allocates runs of free blocks from a 1024-block bitmap (32 words of 32 bits,
// bit set = free), first fit from block 0, and keeps a free count. One word in
// gives one word out. For an allocate, the bitmap words before the first free
// block are scanned one per cycle, and each word the run covers takes a count
// step and a clear step on the single bitmap word port. The next word is taken
// once the current one has left the controller, while the result may still be
// waiting in the output register. map_bytes is written on the cfg channel only
// while idle; values above 128 saturate.
module bitmap_first_fit_run_allocator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [10:0] request_length,
    input  wire logic [4:0]  word_index,
    input  wire logic [31:0] word_data,
    input  wire logic [10:0] new_free_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [9:0]       start_block,
    output logic [10:0]      run_length,
    output logic [10:0]      free_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    bffra_pkg::cmd_t  cmd;
    bffra_pkg::stat_t stat;

    bffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bffra_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .request_length (request_length),
        .word_index     (word_index),
        .word_data      (word_data),
        .new_free_count (new_free_count),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .start_block    (start_block),
        .run_length     (run_length),
        .free_count     (free_count)
    );

    // a failed or non-allocate word reports no run
    `BFFRA_ASSERT_NOW(a_fail_no_run, out_valid && status != bffra_pkg::ST_OK, run_length == '0 && start_block == '0, "failed allocate reports a run")

    // a result is only loaded into an empty or draining output register
    `BFFRA_ASSERT_NOW(a_no_overwrite, cmd.finish, !(out_valid && !out_ready), "result overwrote a pending word")

    // one word in flight: input closes the cycle after acceptance
    `BFFRA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken while busy")

endmodule

`default_nettype wire

### design/bffra_ctrl.sv
// Controller state machine of the bitmap first-fit run allocator
`timescale 1ns / 1ps
`default_nettype none

module bffra_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire bffra_pkg::stat_t stat,
    output bffra_pkg::cmd_t       cmd
);

    bffra_pkg::state_t state_reg;
    bffra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bffra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bffra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bffra_pkg::S_CHECK;
                end
            end
            bffra_pkg::S_CHECK:
            begin
                if (stat.action == bffra_pkg::ACT_ALLOC && !stat.req_zero && !stat.free_zero)
                begin
                    state_next = bffra_pkg::S_SCAN;
                end
                else
                begin
                    state_next = bffra_pkg::S_FINISH;
                end
            end
            bffra_pkg::S_SCAN:
            begin
                priority if (stat.scan_end)
                begin
                    state_next = bffra_pkg::S_FINISH;
                end
                else if (stat.scan_found)
                begin
                    state_next = bffra_pkg::S_RUN_CNT;
                end
            end
            bffra_pkg::S_RUN_CNT:
            begin
                state_next = bffra_pkg::S_RUN_CLR;
            end
            bffra_pkg::S_RUN_CLR:
            begin
                state_next = stat.run_done ? bffra_pkg::S_FINISH : bffra_pkg::S_RUN_CNT;
            end
            bffra_pkg::S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = bffra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bffra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.code  = bffra_pkg::ST_OK;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            bffra_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cfg_ready     = 1'b1;
                cmd.accept    = in_valid;
                cmd.cfg_write = cfg_valid;
            end
            bffra_pkg::S_CHECK:
            begin
                unique case (stat.action)
                    bffra_pkg::ACT_ALLOC:
                    begin
                        priority if (stat.req_zero)
                        begin
                            cmd.set_code = 1'b1;
                            cmd.code     = bffra_pkg::ST_BAD_LENGTH;
                        end
                        else if (stat.free_zero)
                        begin
                            cmd.set_code = 1'b1;
                            cmd.code     = bffra_pkg::ST_NO_SPACE;
                        end
                    end
                    bffra_pkg::ACT_WRITE: cmd.load_word  = 1'b1;
                    bffra_pkg::ACT_COUNT: cmd.load_count = 1'b1;
                    default:              cmd.set_code   = 1'b0;
                endcase
            end
            bffra_pkg::S_SCAN:
            begin
                priority if (stat.scan_end)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = bffra_pkg::ST_INCONSISTENT;
                end
                else if (stat.scan_found)
                begin
                    cmd.scan_hit = 1'b1;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            bffra_pkg::S_RUN_CNT: cmd.run_count = 1'b1;
            bffra_pkg::S_RUN_CLR: cmd.run_clear = 1'b1;
            bffra_pkg::S_FINISH:  cmd.finish    = !stat.out_busy;
            default:              cmd.finish    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### design/bffra_dp.sv
// Datapath of the bitmap first-fit run allocator: bitmap, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module bffra_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bffra_pkg::cmd_t  cmd,
    output bffra_pkg::stat_t      stat,
    input  wire logic [1:0]       action,
    input  wire logic [10:0]      request_length,
    input  wire logic [4:0]       word_index,
    input  wire logic [31:0]      word_data,
    input  wire logic [10:0]      new_free_count,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [1:0]            status,
    output logic [9:0]            start_block,
    output logic [10:0]           run_length,
    output logic [10:0]           free_count
);

    logic [31:0] map_reg [bffra_pkg::WORD_COUNT];
    logic [7:0]  map_bytes_reg;
    logic [10:0] free_reg;

    logic [1:0]  act_reg;
    logic [10:0] req_reg;
    logic [4:0]  widx_reg;
    logic [31:0] wdata_reg;
    logic [10:0] nfc_reg;
    logic [5:0]  wptr_reg;
    logic [4:0]  pos_reg;
    logic [9:0]  start_reg;
    logic [10:0] len_reg;
    logic [1:0]  code_reg;
    logic [5:0]  cnt_reg;
    logic        more_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [9:0]  start_out_reg;
    logic [10:0] length_out_reg;
    logic [10:0] free_out_reg;

    logic [8:0]  bytes_up;
    logic [5:0]  words_used;
    logic [8:0]  bytes_left;
    logic [31:0] use_mask;
    logic [31:0] rd_word;
    logic [31:0] use_word;
    logic [5:0]  hit_idx;
    logic [31:0] filled;
    logic [5:0]  end_idx;
    logic [5:0]  avail;
    logic [5:0]  take;
    logic [5:0]  pos_end;
    logic [31:0] clr_mask;
    logic [10:0] free_sub;
    logic [7:0]  cfg_sat;

    // words of map in use, and the in-use bits of the current word
    assign bytes_up   = {1'b0, map_bytes_reg} + 9'd3;
    assign words_used = bytes_up[7:2];
    assign bytes_left = {1'b0, map_bytes_reg} - {1'b0, wptr_reg, 2'b00};
    assign use_mask   = (bytes_left[8:2] != '0) ? '1
                        : bffra_pkg::low_mask({bytes_left[2:0], 3'b000});

    assign rd_word  = map_reg[wptr_reg[4:0]];
    assign use_word = rd_word & use_mask;
    assign hit_idx  = bffra_pkg::lsb_index(use_word);

    // end of the free run from pos_reg: first clear bit at or above it
    assign filled   = use_word | bffra_pkg::low_mask({1'b0, pos_reg});
    assign end_idx  = bffra_pkg::lsb_index(~filled);
    assign avail    = end_idx - {1'b0, pos_reg};
    assign take     = ({5'b0, avail} > req_reg) ? req_reg[5:0] : avail;

    assign pos_end  = {1'b0, pos_reg} + cnt_reg;
    assign clr_mask = bffra_pkg::low_mask(pos_end) & ~bffra_pkg::low_mask({1'b0, pos_reg});

    assign free_sub = (free_reg > len_reg) ? free_reg - len_reg : '0;
    assign cfg_sat  = (cfg_data > 8'(bffra_pkg::MAP_BYTES)) ? 8'(bffra_pkg::MAP_BYTES) : cfg_data;

    assign stat.action     = act_reg;
    assign stat.req_zero   = (req_reg == '0);
    assign stat.free_zero  = (free_reg == '0);
    assign stat.scan_end   = (wptr_reg == words_used);
    assign stat.scan_found = (use_word != '0);
    assign stat.run_done   = (req_reg == {5'b0, cnt_reg}) || !more_reg
                             || (wptr_reg + 6'd1 == words_used);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bffra_pkg::WORD_COUNT; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cmd.load_word)
        begin
            map_reg[widx_reg] <= wdata_reg;
        end
        else if (cmd.run_clear)
        begin
            map_reg[wptr_reg[4:0]] <= rd_word & ~clr_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_bytes_reg <= 8'(bffra_pkg::MAP_BYTES);
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                map_bytes_reg <= cfg_sat;
            end
            if (cmd.load_count)
            begin
                free_reg <= nfc_reg;
            end
            else if (cmd.finish)
            begin
                free_reg <= free_sub;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg   <= action;
            req_reg   <= request_length;
            widx_reg  <= word_index;
            wdata_reg <= word_data;
            nfc_reg   <= new_free_count;
            wptr_reg  <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            code_reg  <= bffra_pkg::ST_OK;
        end
        else
        begin
            if (cmd.set_code)
            begin
                code_reg <= cmd.code;
            end
            if (cmd.scan_next)
            begin
                wptr_reg <= wptr_reg + 6'd1;
            end
            if (cmd.scan_hit)
            begin
                pos_reg   <= hit_idx[4:0];
                start_reg <= {wptr_reg[4:0], hit_idx[4:0]};
            end
            if (cmd.run_count)
            begin
                cnt_reg  <= take;
                more_reg <= (end_idx == 6'(bffra_pkg::WORD_BITS));
            end
            if (cmd.run_clear)
            begin
                req_reg  <= req_reg - {5'b0, cnt_reg};
                len_reg  <= len_reg + {5'b0, cnt_reg};
                wptr_reg <= wptr_reg + 6'd1;
                pos_reg  <= '0;
            end
        end
        if (cmd.finish)
        begin
            status_reg     <= code_reg;
            start_out_reg  <= start_reg;
            length_out_reg <= len_reg;
            free_out_reg   <= cmd.load_count ? nfc_reg : free_sub;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_block = start_out_reg;
    assign run_length  = length_out_reg;
    assign free_count  = free_out_reg;

endmodule

`default_nettype wire

### verif/tb_bitmap_first_fit_run_allocator_unit.sv
// Testbench for the bitmap first-fit run allocator: queued words, inline predictor, result checks
`timescale 1ns / 1ps

module tb_bitmap_first_fit_run_allocator_unit;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  act;
        logic [10:0] req;
        logic [4:0]  widx;
        logic [31:0] wdata;
        logic [10:0] nfc;
    } alloc_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  start;
        logic [10:0] len;
        logic [10:0] count;
    } alloc_result_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [1:0]  action         = '0;
    logic [10:0] request_length = '0;
    logic [4:0]  word_index     = '0;
    logic [31:0] word_data      = '0;
    logic [10:0] new_free_count = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [1:0]  status;
    logic [9:0]  start_block;
    logic [10:0] run_length;
    logic [10:0] free_count;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data       = '0;

    alloc_word_t   pending_words[$];
    alloc_result_t expected_results[$];
    alloc_word_t   cur_word;

    // predictor state
    logic [31:0] model_map [bffra_pkg::WORD_COUNT];
    logic [10:0] model_free;
    int          model_map_bytes;

    int send_idle_pct;
    int recv_idle_pct;
    int recv_stall_left;
    int quiet_cycles;
    int fail_count;

    always #1 clk = ~clk;

    bitmap_first_fit_run_allocator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .request_length (request_length),
        .word_index     (word_index),
        .word_data      (word_data),
        .new_free_count (new_free_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .start_block    (start_block),
        .run_length     (run_length),
        .free_count     (free_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // applies one word to the predictor state and returns the result it should give
    function automatic alloc_result_t allocator_step(input alloc_word_t w);
        alloc_result_t r;
        int            nblk;
        int            b;
        r    = '0;
        nblk = 0;
        b    = 0;
        case (w.act)
            bffra_pkg::ACT_WRITE:
            begin
                if (int'(w.widx) < bffra_pkg::WORD_COUNT)
                    model_map[w.widx] = w.wdata;
            end
            bffra_pkg::ACT_COUNT:
            begin
                model_free = w.nfc;
            end
            bffra_pkg::ACT_ALLOC:
            begin
                if (w.req == '0)
                    r.status = bffra_pkg::ST_BAD_LENGTH;
                else if (model_free == '0)
                    r.status = bffra_pkg::ST_NO_SPACE;
                else
                begin
                    nblk = model_map_bytes * 8;
                    while (b < nblk && !model_map[b / 32][b % 32])
                        b++;
                    if (b >= nblk)
                        r.status = bffra_pkg::ST_INCONSISTENT;
                    else
                    begin
                        r.start = 10'(b);
                        while (b < nblk && r.len < w.req && model_map[b / 32][b % 32])
                        begin
                            model_map[b / 32][b % 32] = 1'b0;
                            r.len++;
                            b++;
                        end
                        model_free = (model_free > r.len) ? model_free - r.len : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = model_free;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(allocator_step(cur_word));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_word = pending_words.pop_front();
                    action         <= cur_word.act;
                    request_length <= cur_word.req;
                    word_index     <= cur_word.widx;
                    word_data      <= cur_word.wdata;
                    new_free_count <= cur_word.nfc;
                    in_valid       <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("unexpected result word", status, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", status, want.status);
                    if (start_block !== want.start)
                        flag_mismatch("start_block", start_block, want.start);
                    if (run_length !== want.len)
                        flag_mismatch("run_length", run_length, want.len);
                    if (free_count !== want.count)
                        flag_mismatch("free_count", free_count, want.count);
                end
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bitmap_first_fit_run_allocator_unit test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_word(input logic [1:0] act, input logic [10:0] req,
                              input logic [4:0] widx, input logic [31:0] wdata,
                              input logic [10:0] nfc);
        alloc_word_t w;
        w.act   = act;
        w.req   = req;
        w.widx  = widx;
        w.wdata = wdata;
        w.nfc   = nfc;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_map_bytes(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_map_bytes = (int'(v) > bffra_pkg::MAP_BYTES) ? bffra_pkg::MAP_BYTES : int'(v);
        @(negedge clk);
    endtask

    // bursts: a few map writes, maybe a count load, then allocations; some noise
    task automatic queue_random(input int target);
        int          in_use;
        int          k;
        logic [31:0] bits;
        logic [10:0] count;
        logic [10:0] len;
        logic [4:0]  idx;
        in_use = (model_map_bytes + 3) / 4;
        if (in_use == 0)
            in_use = 1;
        while (pending_words.size() < target)
        begin
            k = $urandom_range(0, 4);
            repeat (k)
            begin
                case ($urandom_range(0, 5))
                    0: bits = 32'hFFFF_FFFF;
                    1: bits = '0;
                    2: bits = $urandom;
                    3: bits = (32'hFFFF_FFFF << $urandom_range(0, 31))
                              & (32'hFFFF_FFFF >> $urandom_range(0, 31));
                    4: bits = $urandom & $urandom & $urandom;
                    default: bits = ~(32'd1 << $urandom_range(0, 31));
                endcase
                if ($urandom_range(0, 3) != 0)
                    idx = 5'($urandom_range(0, in_use - 1));
                else
                    idx = 5'($urandom);
                queue_word(bffra_pkg::ACT_WRITE, 11'($urandom), idx, bits, 11'($urandom));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0: count = '0;
                    1: count = 11'($urandom_range(1025, 2047));
                    2: count = 11'($urandom_range(1, 8));
                    default: count = 11'($urandom_range(1, 1024));
                endcase
                queue_word(bffra_pkg::ACT_COUNT, 11'($urandom), 5'($urandom), $urandom, count);
            end
            k = $urandom_range(1, 6);
            repeat (k)
            begin
                case ($urandom_range(0, 19))
                    0: len = '0;
                    1: len = 11'($urandom_range(1025, 2047));
                    2, 3: len = 11'($urandom_range(1, 1024));
                    4, 5, 6: len = 11'($urandom_range(1, 200));
                    default: len = 11'($urandom_range(1, 16));
                endcase
                queue_word(bffra_pkg::ACT_ALLOC, len, 5'($urandom), $urandom, 11'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                queue_word(bffra_pkg::ACT_NONE, 11'($urandom), 5'($urandom), $urandom,
                           11'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < bffra_pkg::WORD_COUNT; i++)
            model_map[i] = '0;
        model_free      = '0;
        model_map_bytes = bffra_pkg::MAP_BYTES;
        send_idle_pct   = 33;
        recv_idle_pct   = 80;
        recv_stall_left = 0;
        fail_count      = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        queue_word(bffra_pkg::ACT_ALLOC, 11'd0, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd1, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_COUNT, 11'd0, 5'd0, 32'h0, 11'd2047);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd2047, 5'd31, 32'hFFFF_FFFF, 11'd2047);
        queue_word(bffra_pkg::ACT_NONE, 11'd2047, 5'd31, 32'hFFFF_FFFF, 11'd2047);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd0, 32'hFFFF_FFFF, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd1, 32'h0000_FFFF, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd1024, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd31, 32'hFFFF_FFFF, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd30, 32'hFFFF_FFFF, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd2047, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_COUNT, 11'd0, 5'd0, 32'h0, 11'd10);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd5, 32'h8000_0000, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd1, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd7, 32'h0000_0F00, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd100, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd9, 32'hFFFF_FFFF, 11'd0);
        queue_word(bffra_pkg::ACT_COUNT, 11'd0, 5'd0, 32'h0, 11'd3);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd50, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd1, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd2, 32'h0000_0001, 11'd0);
        queue_word(bffra_pkg::ACT_COUNT, 11'd0, 5'd0, 32'h0, 11'd1);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd1, 5'd0, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_WRITE, 11'd0, 5'd31, 32'h0, 11'd0);
        queue_word(bffra_pkg::ACT_ALLOC, 11'd5, 5'd0, 32'h0, 11'd0);
        wait_drained();

        // oversize map setting; long receiver hold-off while the sender keeps going
        write_map_bytes(8'd255);
        recv_stall_left = 300;
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 33;
        write_map_bytes(8'd1);
        queue_random(300);
        wait_drained();
        write_map_bytes(8'd0);
        queue_random(60);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_map_bytes(8'd128);
        queue_random(700);
        wait_drained();
        write_map_bytes(8'($urandom_range(2, 127)));
        recv_stall_left = 200;
        queue_random(400);
        wait_drained();

        repeat (100) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch("outstanding results", expected_results.size(), 0);
        if (fail_count == 0)
            $display("bitmap_first_fit_run_allocator_unit test passed");
        else
            $display("bitmap_first_fit_run_allocator_unit test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/bffra_pkg.sv
design/bffra_ctrl.sv
design/bffra_dp.sv
design/bitmap_first_fit_run_allocator_unit.sv
verif/tb_bitmap_first_fit_run_allocator_unit.sv
